// File: rtl/nearest_sample_distance_score_defines.svh
// assertion macros shared by the distance score block
`ifndef NEAREST_SAMPLE_DISTANCE_SCORE_DEFINES_SVH
`define NEAREST_SAMPLE_DISTANCE_SCORE_DEFINES_SVH

// same-cycle implication, checked on every clk edge out of reset
`define NSDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nsds assertion failed");

// next-cycle implication
`define NSDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nsds assertion failed");

`endif

// File: rtl/nsds_pkg.sv
// shared types and constants of the nearest sample distance score block
package nsds_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int MAX_DIMS    = 16;
  localparam int PID_W       = 20;
  localparam int VAL_W       = 16;
  localparam int SLOT_W      = 4;
  localparam int DIM_W       = 4;
  localparam int NUM_W       = 5;
  localparam int SCORE_W     = 18;
  localparam int DIM_IDX_W   = $clog2(MAX_DIMS);

  // squared difference and accumulated distance
  localparam int SQ_W        = 2 * VAL_W;
  localparam int SUM_W       = SQ_W + $clog2(MAX_DIMS) + 1;

  // square root unit sizes
  localparam int RAD_W       = SUM_W + (SUM_W % 2);
  localparam int ROOT_W      = RAD_W / 2;
  localparam int REM_W       = ROOT_W + 2;
  localparam int ROOT_STEPS  = ROOT_W;
  localparam int CNT_W       = $clog2(ROOT_STEPS);

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [SLOT_W-1:0]       sample_slot;
    logic [DIM_W-1:0]        dim_index;
    logic [PID_W-1:0]        point_id;
    logic signed [VAL_W-1:0] elem_value;
    logic                    last_elem;
  } in_item_t;

  typedef struct packed {
    logic [PID_W-1:0]   scored_point;
    logic [SCORE_W-1:0] score;
    logic               found_positive;
  } out_item_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic wr;
    logic sq;
    logic acc;
    logic active;
  } cell_ctl_t;

  // running minimum handed down the cell chain
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] best;
  } token_t;

  // square root unit status
  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SEARCH,
    ST_ROOT,
    ST_HOLD
  } fsm_t;

endpackage

// File: rtl/nsds_cell.sv
// one sample slot: stored vector, running distance and minimum stage
module nsds_cell
  import nsds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  in_item_t  item,
  input  token_t    tok_in,
  output token_t    tok_out
);

  logic signed [VAL_W-1:0] samp_mem [MAX_DIMS];
  logic [PID_W-1:0]        id_r;
  logic signed [VAL_W-1:0] samp_r;
  logic signed [VAL_W-1:0] qval_r;
  logic [SQ_W-1:0]         sq_r;
  logic [SUM_W-1:0]        sum_r;
  token_t                  tok_r;

  logic [DIM_IDX_W-1:0]    dim;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W:0]          mag;
  logic [VAL_W-1:0]        mag_w;
  logic [SQ_W-1:0]         prod;
  logic                    eligible;
  logic                    take;

  assign dim = item.dim_index[DIM_IDX_W-1:0];

  // sample store, one coordinate per load beat
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      samp_mem[dim] <= item.elem_value;
      id_r          <= item.point_id;
    end
  end

  // registered read of the stored coordinate beside the query coordinate
  always_ff @(posedge clk) begin
    if (ctl.sq) begin
      samp_r <= samp_mem[dim];
      qval_r <= item.elem_value;
    end
  end

  // squared difference for this dimension
  always_comb begin
    diff  = {qval_r[VAL_W-1], qval_r} - {samp_r[VAL_W-1], samp_r};
    mag   = diff[VAL_W] ? (~diff + 1'b1) : diff;
    mag_w = mag[VAL_W-1:0];
    prod  = mag_w * mag_w;
  end

  always_ff @(posedge clk) begin
    sq_r <= prod;
  end

  // partial sum, cleared as the minimum token passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (tok_in.valid) begin
      sum_r <= '0;
    end else if (ctl.acc) begin
      sum_r <= sum_r + SUM_W'(sq_r);
    end
  end

  // minimum positive distance, skipping the query's own identity
  always_comb begin
    eligible = ctl.active && (id_r != item.point_id) && (sum_r != '0);
    take     = eligible && ((tok_in.best == '0) || (sum_r < tok_in.best));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_in.valid;
    end
    tok_r.best <= take ? sum_r : tok_in.best;
  end

  assign tok_out = tok_r;

endmodule

// File: rtl/nsds_sqrt.sv
// iterative floor square root, one result bit per cycle
module nsds_sqrt
  import nsds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output root_stat_t        stat,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  // one restoring step
  always_comb begin
    rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = (REM_W+2)'({root_r, 2'b01});
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_W'(radicand);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

// File: rtl/nearest_sample_distance_score.sv
// top level: sample cell chain, minimum search and square root scoring
//
//  port group  dir  handshake            payload
//  in_         in   in_valid/in_stall    in_item_t
//  out_        out  out_valid/out_stall  out_item_t
//  cfg_        in   cfg_we               num_samples, 5 bits
//
// load beats and non-final query beats are taken one per cycle while in_stall
// is low; a beat passes through the stored coordinate read, the squared
// differences and the accumulate in each cell, each registered.
// a final query beat has its result registered once its sums finish, the
// minimum has passed down the cell chain, the square root unit has loaded and
// stepped, and the output register is free of a stalled result.
// in_stall is high from the final query beat until its result is registered.
// reset clears sums and control; sample store holds garbage until loaded.
module nearest_sample_distance_score
  import nsds_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [NUM_W-1:0] cfg_wdata
);

`include "nearest_sample_distance_score_defines.svh"

  fsm_t              state_r;
  fsm_t              state_nxt;
  logic [NUM_W-1:0]  num_r;
  in_item_t          item_r;
  logic              v1_r;
  logic              mul_r;
  logic              acc_r;
  logic              last2_r;
  logic              last3_r;
  logic              start_r;
  logic              found_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              accept;
  logic              q1;
  logic              dim_ok;
  logic              last1;
  logic [NUM_W-1:0]  active_cnt;
  logic              out_free;
  logic              load_out;
  logic              root_start;
  root_stat_t        root_stat;
  logic [ROOT_W-1:0] root;
  token_t            tok [MAX_SAMPLES+1];

  assign accept = in_valid && !in_stall;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= NUM_W'(MAX_SAMPLES);
    end else if (cfg_we) begin
      num_r <= cfg_wdata;
    end
  end

  assign active_cnt = (num_r > NUM_W'(MAX_SAMPLES)) ? NUM_W'(MAX_SAMPLES) : num_r;

  // input beat register
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  always_comb begin
    dim_ok = ({1'b0, item_r.dim_index} < (DIM_W+1)'(MAX_DIMS));
    q1     = v1_r && (item_r.req_type == REQ_QUERY);
    last1  = q1 && item_r.last_elem;
  end

  // pipeline flags: read, square, accumulate, then launch the search token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      mul_r   <= 1'b0;
      acc_r   <= 1'b0;
      last2_r <= 1'b0;
      last3_r <= 1'b0;
      start_r <= 1'b0;
    end else begin
      v1_r    <= accept;
      mul_r   <= q1 && dim_ok;
      acc_r   <= mul_r;
      last2_r <= last1;
      last3_r <= last2_r;
      start_r <= last3_r;
    end
  end

  assign tok[0].valid = start_r;
  assign tok[0].best  = '0;

  // row of sample cells
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    cell_ctl_t ctl;

    always_comb begin
      ctl.wr     = v1_r && (item_r.req_type == REQ_LOAD) && dim_ok &&
                   ({1'b0, item_r.sample_slot} == (SLOT_W+1)'(i));
      ctl.sq     = q1 && dim_ok;
      ctl.acc    = acc_r;
      ctl.active = (NUM_W'(i) < active_cnt);
    end

    nsds_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .item    (item_r),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // presence of a positive distance
  always_ff @(posedge clk) begin
    if (tok[MAX_SAMPLES].valid) begin
      found_r <= (tok[MAX_SAMPLES].best != '0);
    end
  end

  nsds_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (tok[MAX_SAMPLES].best),
    .stat     (root_stat),
    .root     (root)
  );

  assign out_free = !out_valid_r || !out_stall;

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (accept && (in_data.req_type == REQ_QUERY) && in_data.last_elem) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok[MAX_SAMPLES].valid) begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_stat.done) begin
          state_nxt = out_free ? ST_RUN : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    root_start = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      ST_RUN:    in_stall = 1'b0;
      ST_SEARCH: root_start = tok[MAX_SAMPLES].valid;
      ST_ROOT:   load_out = root_stat.done && out_free;
      ST_HOLD:   load_out = out_free;
      default:   in_stall = 1'b1;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.scored_point   <= item_r.point_id;
      out_data_r.score          <= root[SCORE_W-1:0];
      out_data_r.found_positive <= found_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks on sequencing
  `NSDS_ASSERT_NOW(a_tok_in_search, tok[MAX_SAMPLES].valid, state_r == ST_SEARCH)
  `NSDS_ASSERT_NOW(a_no_out_overwrite, load_out, !out_valid_r || !out_stall)
  `NSDS_ASSERT_NOW(a_root_idle_at_start, root_start, !root_stat.busy)
  `NSDS_ASSERT_NOW(a_last_blocks_input, last2_r || last3_r || start_r, in_stall)
  `NSDS_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_r)

endmodule
